/* rtl/elgd_pkg.sv */
package elgd_pkg;

    localparam int MOD_WIDTH_DEF = 16;
    localparam int BYTE_WIDTH    = 8;
    localparam int CFG_IDX_WIDTH = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PRIME_MODULUS    = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PRIVATE_EXPONENT = 1'd1;

    localparam int PRIME_RESET    = 3;
    localparam int EXPONENT_RESET = 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_P,
        ST_RED_A,
        ST_RED_B_INIT,
        ST_RED_B,
        ST_CHK_A,
        ST_EXP_TEST,
        ST_MUL_ACC,
        ST_SQ_INIT,
        ST_MUL_SQ,
        ST_MUL_FIN,
        ST_WAIT_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_INIT_A,
        OP_RED_INIT_B,
        OP_RED_STEP,
        OP_RED_STORE_A,
        OP_RED_STORE_B,
        OP_EXP_INIT_A,
        OP_EXP_INIT_S,
        OP_MUL_INIT_ACC,
        OP_MUL_INIT_SQ,
        OP_MUL_INIT_FIN,
        OP_MUL_STEP,
        OP_STORE_ACC,
        OP_STORE_SQ,
        OP_RESULT_ZERO,
        OP_RESULT_MUL
    } dp_op_t;

    typedef struct packed {
        logic p_small;
        logic a_zero;
        logic red_done;
        logic mul_done;
        logic e_zero;
        logic e_lsb;
    } dp_status_t;

endpackage

/* rtl/elgamal_decrypt_char_unit.sv */
// ElGamal decryption, one ciphertext pair (cipher_a, cipher_b) per request: both parts are
// reduced mod p, the secret s = a^x mod p is inverted as s^(p-2) mod p, and the plaintext
// b * s^-1 mod p comes out as plain_residue with its low byte on plain_byte. A modulus below
// two, or a part a that is zero mod p, gives zero. Write prime_modulus and private_exponent
// only while the unit is idle. One request is processed at a time; the input parts are reduced
// by a restoring remainder, one step per bit, and all multiplications run through one
// shift-and-add modular multiplier that takes one step per bit of its multiplier operand and
// stops once that operand is spent. Each exponentiation costs one squaring per exponent bit
// plus one more multiplication for every set bit, with a bit test for each, so a request
// finishes sooner for short exponents and small operands. A new request is taken while the
// previous result is still waiting on out_stall.
module elgamal_decrypt_char_unit #(
    parameter int MOD_WIDTH = elgd_pkg::MOD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [elgd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [MOD_WIDTH-1:0]               cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [MOD_WIDTH-1:0]               cipher_a,
    input  logic [MOD_WIDTH-1:0]               cipher_b,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [MOD_WIDTH-1:0]               plain_residue,
    output logic [elgd_pkg::BYTE_WIDTH-1:0]    plain_byte
);

    elgd_pkg::dp_op_t     op;
    elgd_pkg::dp_status_t status;
    logic [MOD_WIDTH-1:0] result;

    elgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .op        (op)
    );

    elgd_datapath #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cipher_a  (cipher_a),
        .cipher_b  (cipher_b),
        .op        (op),
        .status    (status),
        .result    (result)
    );

    assign plain_residue = result;
    assign plain_byte    = result[elgd_pkg::BYTE_WIDTH-1:0];

endmodule

/* rtl/elgd_datapath.sv */
module elgd_datapath #(
    parameter int MOD_WIDTH = elgd_pkg::MOD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [elgd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [MOD_WIDTH-1:0]               cfg_data,
    input  logic [MOD_WIDTH-1:0]               cipher_a,
    input  logic [MOD_WIDTH-1:0]               cipher_b,
    input  elgd_pkg::dp_op_t                   op,
    output elgd_pkg::dp_status_t               status,
    output logic [MOD_WIDTH-1:0]               result
);

    localparam int W     = MOD_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     p_reg;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     dsh_reg;
    logic [W-1:0]     rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     sq_reg;
    logic [W-1:0]     e_reg;
    logic [W-1:0]     macc_reg;
    logic [W-1:0]     mrun_reg;
    logic [W-1:0]     my_reg;
    logic [W-1:0]     res_reg;

    logic [W:0]       red_t;
    logic [W:0]       red_d;
    logic [W-1:0]     rem_step;
    logic [W-1:0]     macc_step;
    logic [W-1:0]     mrun_step;

    // Sum of two residues below p, folded back once.
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] p);
        logic [W:0] s;
        logic [W:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, p};
        add_mod = (s >= {1'b0, p}) ? d[W-1:0] : s[W-1:0];
    endfunction

    // One restoring remainder step: bring in the next dividend bit.
    assign red_t    = {rem_reg, dsh_reg[W-1]};
    assign red_d    = red_t - {1'b0, p_reg};
    assign rem_step = (red_t >= {1'b0, p_reg}) ? red_d[W-1:0] : red_t[W-1:0];

    assign macc_step = my_reg[0] ? add_mod(macc_reg, mrun_reg, p_reg) : macc_reg;
    assign mrun_step = add_mod(mrun_reg, mrun_reg, p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= W'(elgd_pkg::PRIME_RESET);
            x_reg <= W'(elgd_pkg::EXPONENT_RESET);
        end
        else if (cfg_write)
        begin
            if (cfg_index == elgd_pkg::REG_PRIME_MODULUS)
                p_reg <= cfg_data;
            else if (cfg_index == elgd_pkg::REG_PRIVATE_EXPONENT)
                x_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            elgd_pkg::OP_NONE:
            begin
            end
            elgd_pkg::OP_LOAD:
            begin
                a_reg <= cipher_a;
                b_reg <= cipher_b;
            end
            elgd_pkg::OP_RED_INIT_A:
            begin
                dsh_reg <= a_reg;
                rem_reg <= '0;
                cnt_reg <= CNT_W'(W);
            end
            elgd_pkg::OP_RED_INIT_B:
            begin
                dsh_reg <= b_reg;
                rem_reg <= '0;
                cnt_reg <= CNT_W'(W);
            end
            elgd_pkg::OP_RED_STEP:
            begin
                rem_reg <= rem_step;
                dsh_reg <= {dsh_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            elgd_pkg::OP_RED_STORE_A:
                a_reg <= rem_reg;
            elgd_pkg::OP_RED_STORE_B:
                b_reg <= rem_reg;
            elgd_pkg::OP_EXP_INIT_A:
            begin
                acc_reg <= W'(1);
                sq_reg  <= a_reg;
                e_reg   <= x_reg;
            end
            elgd_pkg::OP_EXP_INIT_S:
            begin
                // Fermat inverse: raise the secret to p-2.
                acc_reg <= W'(1);
                sq_reg  <= acc_reg;
                e_reg   <= p_reg - W'(2);
            end
            elgd_pkg::OP_MUL_INIT_ACC:
            begin
                macc_reg <= '0;
                mrun_reg <= acc_reg;
                my_reg   <= sq_reg;
            end
            elgd_pkg::OP_MUL_INIT_SQ:
            begin
                macc_reg <= '0;
                mrun_reg <= sq_reg;
                my_reg   <= sq_reg;
            end
            elgd_pkg::OP_MUL_INIT_FIN:
            begin
                macc_reg <= '0;
                mrun_reg <= b_reg;
                my_reg   <= acc_reg;
            end
            elgd_pkg::OP_MUL_STEP:
            begin
                macc_reg <= macc_step;
                mrun_reg <= mrun_step;
                my_reg   <= {1'b0, my_reg[W-1:1]};
            end
            elgd_pkg::OP_STORE_ACC:
                acc_reg <= macc_reg;
            elgd_pkg::OP_STORE_SQ:
            begin
                sq_reg <= macc_reg;
                e_reg  <= {1'b0, e_reg[W-1:1]};
            end
            elgd_pkg::OP_RESULT_ZERO:
                res_reg <= '0;
            elgd_pkg::OP_RESULT_MUL:
                res_reg <= macc_reg;
            default:
            begin
            end
        endcase
    end

    assign status.p_small  = (p_reg < W'(2));
    assign status.a_zero   = (a_reg == '0);
    assign status.red_done = (cnt_reg == '0);
    assign status.mul_done = (my_reg == '0);
    assign status.e_zero   = (e_reg == '0);
    assign status.e_lsb    = e_reg[0];

    assign result = res_reg;

    a_rem_below_p: assert property (@(posedge clk) disable iff (!rst_n)
        op == elgd_pkg::OP_RED_STEP |=> rem_reg < p_reg)
        else $error("remainder not reduced below the modulus");

    a_macc_below_p: assert property (@(posedge clk) disable iff (!rst_n)
        op == elgd_pkg::OP_MUL_STEP |=> macc_reg < p_reg && mrun_reg < p_reg)
        else $error("modular product left the residue range");

endmodule

/* rtl/elgd_ctrl.sv */
module elgd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  elgd_pkg::dp_status_t status,
    output elgd_pkg::dp_op_t     op
);

    elgd_pkg::state_t state_reg, state_next;
    logic             phase_reg, phase_next;
    logic             zero_reg, zero_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= elgd_pkg::ST_IDLE;
            phase_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && out_stall;
        op             = elgd_pkg::OP_NONE;

        unique case (state_reg)
            elgd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = elgd_pkg::OP_LOAD;
                    state_next = elgd_pkg::ST_CHK_P;
                end
            end
            elgd_pkg::ST_CHK_P:
            begin
                if (status.p_small)
                begin
                    zero_next  = 1'b1;
                    state_next = elgd_pkg::ST_WAIT_OUT;
                end
                else
                begin
                    op         = elgd_pkg::OP_RED_INIT_A;
                    state_next = elgd_pkg::ST_RED_A;
                end
            end
            elgd_pkg::ST_RED_A:
            begin
                if (status.red_done)
                begin
                    op         = elgd_pkg::OP_RED_STORE_A;
                    state_next = elgd_pkg::ST_RED_B_INIT;
                end
                else
                    op = elgd_pkg::OP_RED_STEP;
            end
            elgd_pkg::ST_RED_B_INIT:
            begin
                op         = elgd_pkg::OP_RED_INIT_B;
                state_next = elgd_pkg::ST_RED_B;
            end
            elgd_pkg::ST_RED_B:
            begin
                if (status.red_done)
                begin
                    op         = elgd_pkg::OP_RED_STORE_B;
                    state_next = elgd_pkg::ST_CHK_A;
                end
                else
                    op = elgd_pkg::OP_RED_STEP;
            end
            elgd_pkg::ST_CHK_A:
            begin
                if (status.a_zero)
                begin
                    zero_next  = 1'b1;
                    state_next = elgd_pkg::ST_WAIT_OUT;
                end
                else
                begin
                    op         = elgd_pkg::OP_EXP_INIT_A;
                    phase_next = 1'b0;
                    state_next = elgd_pkg::ST_EXP_TEST;
                end
            end
            elgd_pkg::ST_EXP_TEST:
            begin
                // The first exponentiation forms the secret, the second its inverse.
                priority if (status.e_zero && !phase_reg)
                begin
                    op         = elgd_pkg::OP_EXP_INIT_S;
                    phase_next = 1'b1;
                end
                else if (status.e_zero)
                begin
                    op         = elgd_pkg::OP_MUL_INIT_FIN;
                    state_next = elgd_pkg::ST_MUL_FIN;
                end
                else if (status.e_lsb)
                begin
                    op         = elgd_pkg::OP_MUL_INIT_ACC;
                    state_next = elgd_pkg::ST_MUL_ACC;
                end
                else
                begin
                    op         = elgd_pkg::OP_MUL_INIT_SQ;
                    state_next = elgd_pkg::ST_MUL_SQ;
                end
            end
            elgd_pkg::ST_MUL_ACC:
            begin
                if (status.mul_done)
                begin
                    op         = elgd_pkg::OP_STORE_ACC;
                    state_next = elgd_pkg::ST_SQ_INIT;
                end
                else
                    op = elgd_pkg::OP_MUL_STEP;
            end
            elgd_pkg::ST_SQ_INIT:
            begin
                op         = elgd_pkg::OP_MUL_INIT_SQ;
                state_next = elgd_pkg::ST_MUL_SQ;
            end
            elgd_pkg::ST_MUL_SQ:
            begin
                if (status.mul_done)
                begin
                    op         = elgd_pkg::OP_STORE_SQ;
                    state_next = elgd_pkg::ST_EXP_TEST;
                end
                else
                    op = elgd_pkg::OP_MUL_STEP;
            end
            elgd_pkg::ST_MUL_FIN:
            begin
                if (status.mul_done)
                begin
                    zero_next  = 1'b0;
                    state_next = elgd_pkg::ST_WAIT_OUT;
                end
                else
                    op = elgd_pkg::OP_MUL_STEP;
            end
            elgd_pkg::ST_WAIT_OUT:
            begin
                // The result register is loaded once the previous request has left it.
                if (!out_valid_reg || !out_stall)
                begin
                    op             = zero_reg ? elgd_pkg::OP_RESULT_ZERO
                                              : elgd_pkg::OP_RESULT_MUL;
                    out_valid_next = 1'b1;
                    state_next     = elgd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = elgd_pkg::ST_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != elgd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == elgd_pkg::ST_CHK_P)
        else $error("accepted request did not start the sequence");

    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == elgd_pkg::ST_WAIT_OUT && out_valid_reg && out_stall
        |=> state_reg == elgd_pkg::ST_WAIT_OUT && out_valid_reg)
        else $error("result overwrote a request still waiting");

    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == elgd_pkg::ST_WAIT_OUT && !(out_valid_reg && out_stall)
        |=> state_reg == elgd_pkg::ST_IDLE && out_valid_reg)
        else $error("finished result was not presented");

endmodule
